### design/assert_macros.svh
// assertion macros used by the dfr checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define DFR_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dfr: same-cycle check failed");

// next-cycle implication, ignored while reset is high
`define DFR_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dfr: next-cycle check failed");

// next-cycle implication that also holds across reset
`define DFR_ASSERT_RST(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("dfr: reset check failed");

`endif

### design/dfr_pkg.sv
// types and constants shared by the dfa recognizer modules
package dfr_pkg;

   localparam int OP_W   = 2;
   localparam int CHAR_W = 8;
   localparam int IDX_W  = 4;
   localparam int ST_W   = 4;
   localparam int CNT_W  = 5;
   localparam int MASK_W = 16;
   localparam int CSR_DW = 32;
   localparam int CSR_AW = 4;

   // item opcodes
   localparam logic [OP_W-1:0] OP_LOAD_SYMBOL = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_TRANS  = 2'd1;
   localparam logic [OP_W-1:0] OP_FEED_CHAR   = 2'd2;
   localparam logic [OP_W-1:0] OP_END_STRING  = 2'd3;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_SYMBOL_COUNT = 2'd0;
   localparam logic [1:0] REG_START_STATE  = 2'd1;
   localparam logic [1:0] REG_ACCEPT_MASK  = 2'd2;

   // classified item handed from front to back
   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      logic [IDX_W-1:0] sym;
      logic             miss;
      logic [ST_W-1:0]  from_state;
      logic [ST_W-1:0]  target_state;
   } cmd_type;

   // one verdict
   typedef struct packed {
      logic            accepted;
      logic            unknown_seen;
      logic [ST_W-1:0] final_state;
   } verdict_type;

   // configuration registers
   typedef struct packed {
      logic [CNT_W-1:0]  symbol_count;
      logic [ST_W-1:0]   start_state;
      logic [MASK_W-1:0] accept_mask;
   } cfg_type;

endpackage

### design/dfr_queue.sv
// small first-in first-out queue of fixed-width items
module dfr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   // depth is a power of two so the pointers wrap by themselves
   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // item storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/dfr_front.sv
// front end: accepts items, keeps the symbol table and classifies characters
module dfr_front #(
   parameter int SLOTS = 16
) (
   input  logic                          clock,
   input  logic                          req_push,
   input  logic [dfr_pkg::OP_W-1:0]      req_opcode,
   input  logic [dfr_pkg::CHAR_W-1:0]    req_char_value,
   input  logic [dfr_pkg::IDX_W-1:0]     req_slot_index,
   input  logic [dfr_pkg::ST_W-1:0]      req_from_state,
   input  logic [dfr_pkg::ST_W-1:0]      req_target_state,
   output logic                          req_full,
   input  dfr_pkg::cfg_type              cfg,
   output logic                          cmd_push,
   output dfr_pkg::cmd_type              cmd_data,
   input  logic                          cmd_full
);
   import dfr_pkg::*;

   localparam int SW = $clog2(SLOTS);
   localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

   logic [CHAR_W-1:0] symbol_ff [SLOTS];
   logic [SLOTS-1:0]  hit;
   logic [IDX_W-1:0]  found;
   logic [CNT_W-1:0]  scan_limit;
   logic              accept;
   logic              sym_write;

   assign req_full  = cmd_full;
   assign accept    = req_push && !cmd_full;
   assign sym_write = accept && (req_opcode == OP_LOAD_SYMBOL)
                      && ({1'b0, req_slot_index} < SLOTS_CNT);

   // symbol table, one byte per slot
   always_ff @(posedge clock) begin
      if (sym_write) begin
         symbol_ff[req_slot_index[SW-1:0]] <= req_char_value;
      end
   end

   // slots beyond the table are never searched
   assign scan_limit = (cfg.symbol_count > SLOTS_CNT) ? SLOTS_CNT : cfg.symbol_count;

   // parallel compare against every slot in use
   always_comb begin
      for (int k = 0; k < SLOTS; k++) begin
         hit[k] = (CNT_W'(k) < scan_limit) && (symbol_ff[k] == req_char_value);
      end
   end

   // lowest matching slot wins
   always_comb begin
      found = '0;
      for (int k = SLOTS - 1; k >= 0; k--) begin
         if (hit[k]) begin
            found = IDX_W'(k);
         end
      end
   end

   // symbol loads finish here, everything else goes to the back end
   assign cmd_push = accept && (req_opcode != OP_LOAD_SYMBOL);

   always_comb begin
      cmd_data.opcode       = req_opcode;
      cmd_data.sym          = (req_opcode == OP_LOAD_TRANS) ? req_slot_index : found;
      cmd_data.miss         = ~|hit;
      cmd_data.from_state   = req_from_state;
      cmd_data.target_state = req_target_state;
   end

endmodule

### design/dfr_back.sv
// back end: transition table, state walk and verdicts
module dfr_back #(
   parameter int ROWS = 16,
   parameter int COLS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_empty,
   input  dfr_pkg::cmd_type     cmd_data,
   output logic                 cmd_pop,
   input  dfr_pkg::cfg_type     cfg,
   input  logic                 rsp_full,
   output logic                 rsp_push,
   output dfr_pkg::verdict_type rsp_data
);
   import dfr_pkg::*;

   localparam int DEPTH = ROWS * COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [CNT_W-1:0] ROWS_CNT = CNT_W'(ROWS);
   localparam logic [CNT_W-1:0] COLS_CNT = CNT_W'(COLS);

   logic [ST_W-1:0] trans_mem [DEPTH];
   logic [ST_W-1:0] rd_data_ff;
   logic            sel_rd_ff, sel_rd_in;
   logic [ST_W-1:0] cur_ff, cur_in;
   logic            in_string_ff, in_string_in;
   logic            reject_ff, reject_in;

   logic [ST_W-1:0] cur_state;
   logic [ST_W-1:0] base_state;
   logic            exec;
   logic            row_ok;
   logic            rd_en, wr_en;
   logic [AW-1:0]   rd_addr, wr_addr;

   // the state after a table step lives in the memory's read register
   assign cur_state  = sel_rd_ff ? rd_data_ff : cur_ff;
   assign base_state = in_string_ff ? cur_state : cfg.start_state;

   // one item a cycle; an end item waits for room in the result queue
   assign exec    = !cmd_empty && ((cmd_data.opcode != OP_END_STRING) || !rsp_full);
   assign cmd_pop = exec;

   // table addressing
   assign row_ok  = ({1'b0, base_state} < ROWS_CNT);
   assign rd_addr = AW'(int'(base_state) * COLS + int'(cmd_data.sym));
   assign wr_addr = AW'(int'(cmd_data.from_state) * COLS + int'(cmd_data.sym));
   assign rd_en   = exec && (cmd_data.opcode == OP_FEED_CHAR) && !reject_ff
                    && !cmd_data.miss && row_ok;
   assign wr_en   = exec && (cmd_data.opcode == OP_LOAD_TRANS)
                    && ({1'b0, cmd_data.from_state} < ROWS_CNT)
                    && ({1'b0, cmd_data.sym} < COLS_CNT);

   // transition table with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         trans_mem[wr_addr] <= cmd_data.target_state;
      end
      if (rd_en) begin
         rd_data_ff <= trans_mem[rd_addr];
      end
   end

   // state walk
   always_comb begin
      cur_in       = cur_ff;
      sel_rd_in    = sel_rd_ff;
      in_string_in = in_string_ff;
      reject_in    = reject_ff;
      if (exec) begin
         case (cmd_data.opcode)
            OP_FEED_CHAR: begin
               in_string_in = 1'b1;
               cur_in       = base_state;
               sel_rd_in    = 1'b0;
               if (!reject_ff) begin
                  if (cmd_data.miss) begin
                     reject_in = 1'b1;
                  end else if (row_ok) begin
                     sel_rd_in = 1'b1;
                  end else begin
                     cur_in = '0;
                  end
               end
            end
            OP_END_STRING: begin
               cur_in       = cfg.start_state;
               sel_rd_in    = 1'b0;
               in_string_in = 1'b0;
               reject_in    = 1'b0;
            end
            default: begin
               // table loads leave the walk alone
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         sel_rd_ff    <= 1'b0;
         in_string_ff <= 1'b0;
         reject_ff    <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         sel_rd_ff    <= sel_rd_in;
         in_string_ff <= in_string_in;
         reject_ff    <= reject_in;
      end
   end

   // verdict for an end item
   assign rsp_push = exec && (cmd_data.opcode == OP_END_STRING);

   always_comb begin
      rsp_data.final_state  = base_state;
      rsp_data.unknown_seen = reject_ff;
      rsp_data.accepted     = !reject_ff && cfg.accept_mask[base_state];
   end

endmodule

### design/table_driven_dfa_recognizer.sv
// top level of the programmable table-driven dfa recognizer
//
// Items enter on the req_ channel (push/full) and verdicts leave on the rsp_
// channel (empty/pop), both queue-like. Symbol loads and transition loads
// fill the tables, character items walk the automaton, and each end item
// yields one verdict: accepted, unknown_seen and final_state.
// Registers sit behind the csr_ port at byte addresses 0 (symbol_count),
// 4 (start_state) and 8 (accept_mask); write them only while idle.
// Throughput is one item per cycle while no end item waits for room in the
// verdict queue: the front compares the byte against all symbol slots in
// parallel, and the back does one transition table read a cycle, the read
// register feeding the next address directly. An accepted item is classified
// into a two-entry queue, then executed by the back end into the two-entry
// verdict queue. If rsp_pop stays low, end items wait in the back end, the
// item queue fills and req_full rises; other items keep flowing while the
// verdict queue has room. Reset empties both queues, clears the registers
// and the walk state; the tables hold no valid data until loaded.
module table_driven_dfa_recognizer #(
   parameter int STATE_LIMIT  = 16,
   parameter int SYMBOL_LIMIT = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [dfr_pkg::OP_W-1:0]      req_opcode,
   input  logic [dfr_pkg::CHAR_W-1:0]    req_char_value,
   input  logic [dfr_pkg::IDX_W-1:0]     req_slot_index,
   input  logic [dfr_pkg::ST_W-1:0]      req_from_state,
   input  logic [dfr_pkg::ST_W-1:0]      req_target_state,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic                          rsp_accepted,
   output logic                          rsp_unknown_seen,
   output logic [dfr_pkg::ST_W-1:0]      rsp_final_state,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [dfr_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [dfr_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [dfr_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import dfr_pkg::*;

   // only 16 states and 16 slots are reachable through the 4-bit fields
   localparam int ROWS = (STATE_LIMIT < 16) ? STATE_LIMIT : 16;
   localparam int COLS = (SYMBOL_LIMIT < 16) ? SYMBOL_LIMIT : 16;

   logic [CNT_W-1:0]  symbol_count_ff;
   logic [ST_W-1:0]   start_state_ff;
   logic [MASK_W-1:0] accept_mask_ff;
   cfg_type           cfg;
   logic              csr_write;

   logic        cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type     cmd_in, cmd_out;
   logic        vrd_push, vrd_full;
   verdict_type vrd_in, vrd_out;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_count_ff <= '0;
         start_state_ff  <= '0;
         accept_mask_ff  <= '0;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_SYMBOL_COUNT: symbol_count_ff <= csr_pwdata[CNT_W-1:0];
            REG_START_STATE:  start_state_ff  <= csr_pwdata[ST_W-1:0];
            REG_ACCEPT_MASK:  accept_mask_ff  <= csr_pwdata[MASK_W-1:0];
            default: begin
               // no register at this address
            end
         endcase
      end
   end

   // register read-back
   always_comb begin
      case (csr_paddr[3:2])
         REG_SYMBOL_COUNT: csr_prdata = CSR_DW'(symbol_count_ff);
         REG_START_STATE:  csr_prdata = CSR_DW'(start_state_ff);
         REG_ACCEPT_MASK:  csr_prdata = CSR_DW'(accept_mask_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg.symbol_count = symbol_count_ff;
   assign cfg.start_state  = start_state_ff;
   assign cfg.accept_mask  = accept_mask_ff;

   // item intake and classification
   dfr_front #(
      .SLOTS (COLS)
   ) u_front (
      .clock            (clock),
      .req_push         (req_push),
      .req_opcode       (req_opcode),
      .req_char_value   (req_char_value),
      .req_slot_index   (req_slot_index),
      .req_from_state   (req_from_state),
      .req_target_state (req_target_state),
      .req_full         (req_full),
      .cfg              (cfg),
      .cmd_push         (cmd_push),
      .cmd_data         (cmd_in),
      .cmd_full         (cmd_full)
   );

   // queue between front and back
   dfr_queue #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (2)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out),
      .empty     (cmd_empty)
   );

   // automaton walk
   dfr_back #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_out),
      .cmd_pop   (cmd_pop),
      .cfg       (cfg),
      .rsp_full  (vrd_full),
      .rsp_push  (vrd_push),
      .rsp_data  (vrd_in)
   );

   // verdict queue towards the receiver
   dfr_queue #(
      .WIDTH ($bits(verdict_type)),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (vrd_push),
      .push_data (vrd_in),
      .full      (vrd_full),
      .pop       (rsp_pop),
      .pop_data  (vrd_out),
      .empty     (rsp_empty)
   );

   assign rsp_accepted     = vrd_out.accepted;
   assign rsp_unknown_seen = vrd_out.unknown_seen;
   assign rsp_final_state  = vrd_out.final_state;

endmodule

### design/dfr_checker.sv
// port-level checks for the dfa recognizer, bound to the top level
`include "assert_macros.svh"

module dfr_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_full,
   input logic                     rsp_empty,
   input logic                     rsp_pop,
   input logic                     rsp_accepted,
   input logic                     rsp_unknown_seen,
   input logic [dfr_pkg::ST_W-1:0] rsp_final_state
);

   // a string with an unknown byte is never accepted
   `DFR_ASSERT_IMP(a_reject_not_accepted, !rsp_empty, !(rsp_accepted && rsp_unknown_seen))

   // reset leaves no verdict and room for items
   `DFR_ASSERT_RST(a_reset_clears, reset, rsp_empty && !req_full)

   // a waiting verdict holds until taken
   `DFR_ASSERT_NXT(a_rsp_holds, !rsp_empty && !rsp_pop,
      !rsp_empty && $stable(rsp_final_state) && $stable(rsp_accepted))

endmodule

bind table_driven_dfa_recognizer dfr_checker u_dfr_checker (.*);
